// File: src/bdm_pkg.sv
// Package for the Bayer MHC 5x5 demosaic block: geometry constants, item
// structs for the pixel, window tap and RGB channels, phase and register codes.
// No dependencies.
`default_nettype none

package bdm_pkg;

  // Geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WCNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = 11;
  localparam int PIX_W      = 8;
  localparam int LINES      = 4;
  localparam int LINE_W     = LINES * PIX_W;

  // Signed width of a kernel sum in units of 1/16
  localparam int KS_W       = 15;

  // Configuration port
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Pixel phase of the window center: {row odd, column odd}
  typedef enum logic [1:0] {
    PH_RED      = 2'b00,
    PH_GREEN_R  = 2'b01,
    PH_GREEN_B  = 2'b10,
    PH_BLUE     = 2'b11
  } phase_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             flush_tick;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             frame_last;
  } pix_out_t;

  // 5x5 window, indexed [row][column], newest column at index 4
  typedef logic [4:0][4:0][PIX_W-1:0] win_t;

  // Masked window taps that the kernels use, vRC = row R, column C
  typedef struct packed {
    phase_t           phase;
    logic             last;
    logic [PIX_W-1:0] v22;
    logic [PIX_W-1:0] v12;
    logic [PIX_W-1:0] v32;
    logic [PIX_W-1:0] v21;
    logic [PIX_W-1:0] v23;
    logic [PIX_W-1:0] v02;
    logic [PIX_W-1:0] v42;
    logic [PIX_W-1:0] v20;
    logic [PIX_W-1:0] v24;
    logic [PIX_W-1:0] v11;
    logic [PIX_W-1:0] v13;
    logic [PIX_W-1:0] v31;
    logic [PIX_W-1:0] v33;
  } tap_t;

endpackage

`default_nettype wire

// File: src/bdm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/bdm_front.sv
// Front end: raster position, line-store RAM read-modify-write and 5x5 window.
// Hands masked window taps to the kernel stage. Depends on bdm_pkg, bdm_ram.
`default_nettype none

module bdm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bdm_pkg::WCNT_W-1:0]   img_w,
  input  logic [bdm_pkg::ROW_W-1:0]    img_h,
  input  logic                         pix_valid,
  output logic                         pix_stall,
  input  bdm_pkg::pix_in_t             pix,
  output logic                         tap_valid,
  input  logic                         tap_stall,
  output bdm_pkg::tap_t                tap
);
  import bdm_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [1:0]       slot;
    logic [4:0]       rmask;
    logic [4:0]       cmask;
    phase_t           phase;
    logic             last;
    logic             emit;
    logic [COL_W-1:0] addr;
  } fe_t;

  logic [COL_W-1:0]        col_pos, col_pos_next;
  logic [ROW_W-1:0]        row_pos, row_pos_next;
  logic                    accept, wrap, ge2, r_ok, emit, last;
  logic [COL_W-1:0]        ic, cc;
  logic [ROW_W-1:0]        ir, rr;
  logic [WCNT_W-1:0]       cc_w, ic1;
  logic [ROW_W:0]          rr_p1, rr_p2;
  logic [WCNT_W:0]         cc_p1, cc_p2;
  logic [4:0]              rmask, cmask;
  fe_t                     s1, s1_next;
  logic                    s1_valid, s1_move;
  logic [LINE_W-1:0]       rd_word, wr_word;
  logic [4:0][PIX_W-1:0]   column;
  logic [1:0]              sel;
  win_t                    win, win_next;

  // Handshake: stage 1 drains when it has no result or the kernel takes it
  assign s1_move   = s1_valid && (!s1.emit || !tap_stall);
  assign pix_stall = s1_valid && !s1_move;
  assign accept    = pix_valid && !pix_stall;
  assign tap_valid = s1_valid && s1.emit;

  // Position of this item and of the window center it completes
  always_comb begin
    wrap  = WCNT_W'(col_pos) >= img_w;
    ic    = wrap ? '0 : col_pos;
    ir    = wrap ? row_pos + ROW_W'(1) : row_pos;
    ge2   = ic >= COL_W'(2);
    rr    = ge2 ? ir - ROW_W'(2) : ir - ROW_W'(3);
    r_ok  = ge2 ? (ir >= ROW_W'(2)) : (ir >= ROW_W'(3));
    emit  = r_ok && (rr < img_h);
    cc_w  = ge2 ? WCNT_W'(ic) - WCNT_W'(2) : WCNT_W'(ic) + img_w - WCNT_W'(2);
    cc    = cc_w[COL_W-1:0];
    rr_p1 = {1'b0, rr} + (ROW_W+1)'(1);
    rr_p2 = {1'b0, rr} + (ROW_W+1)'(2);
    cc_p1 = {1'b0, WCNT_W'(cc)} + (WCNT_W+1)'(1);
    cc_p2 = {1'b0, WCNT_W'(cc)} + (WCNT_W+1)'(2);
    rmask = {rr_p2 < {1'b0, img_h}, rr_p1 < {1'b0, img_h}, 1'b1,
             rr >= ROW_W'(1), rr >= ROW_W'(2)};
    cmask = {cc_p2 < {1'b0, img_w}, cc_p1 < {1'b0, img_w}, 1'b1,
             cc >= COL_W'(1), cc >= COL_W'(2)};
    last  = emit && (rr == img_h - ROW_W'(1)) &&
            (WCNT_W'(cc) == img_w - WCNT_W'(1));
    ic1   = WCNT_W'(ic) + WCNT_W'(1);

    col_pos_next = col_pos;
    row_pos_next = row_pos;
    if (accept) begin
      if (last) begin
        col_pos_next = '0;
        row_pos_next = '0;
      end else if (ic1 >= img_w) begin
        col_pos_next = '0;
        row_pos_next = ir + ROW_W'(1);
      end else begin
        col_pos_next = ic1[COL_W-1:0];
        row_pos_next = ir;
      end
    end

    s1_next.x     = pix.flush_tick ? '0 : pix.pixel_in;
    s1_next.slot  = ir[1:0];
    s1_next.rmask = rmask;
    s1_next.cmask = cmask;
    s1_next.phase = phase_t'({rr[0], cc[0]});
    s1_next.last  = last;
    s1_next.emit  = emit;
    s1_next.addr  = ic;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      s1_valid <= 1'b0;
    end else begin
      col_pos  <= col_pos_next;
      row_pos  <= row_pos_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Payload registers: stage 1 item and the window
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
    if (s1_move) begin
      win <= win_next;
    end
  end

  // Line stores: one word per column, one byte per row slot. The next
  // item always reads a different column than the one written back, so
  // read and write-back never collide.
  bdm_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1.addr),
    .wdata (wr_word),
    .re    (accept),
    .raddr (ic),
    .rdata (rd_word)
  );

  // Build the new column, the write-back word and the shifted window
  always_comb begin
    sel = '0;
    for (int k = 0; k < LINES; k++) begin
      sel       = s1.slot + 2'(k);
      column[k] = rd_word[{sel, 3'b000} +: PIX_W];
    end
    column[4] = s1.x;

    wr_word = rd_word;
    wr_word[{s1.slot, 3'b000} +: PIX_W] = s1.x;

    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 4; c++) begin
        win_next[r][c] = win[r][c+1];
      end
      win_next[r][4] = column[r];
    end
  end

  // Mask taps that fall outside the frame
  always_comb begin
    tap.phase = s1.phase;
    tap.last  = s1.last;
    tap.v22   = win_next[2][2];
    tap.v12   = s1.rmask[1] ? win_next[1][2] : '0;
    tap.v32   = s1.rmask[3] ? win_next[3][2] : '0;
    tap.v21   = s1.cmask[1] ? win_next[2][1] : '0;
    tap.v23   = s1.cmask[3] ? win_next[2][3] : '0;
    tap.v02   = s1.rmask[0] ? win_next[0][2] : '0;
    tap.v42   = s1.rmask[4] ? win_next[4][2] : '0;
    tap.v20   = s1.cmask[0] ? win_next[2][0] : '0;
    tap.v24   = s1.cmask[4] ? win_next[2][4] : '0;
    tap.v11   = (s1.rmask[1] && s1.cmask[1]) ? win_next[1][1] : '0;
    tap.v13   = (s1.rmask[1] && s1.cmask[3]) ? win_next[1][3] : '0;
    tap.v31   = (s1.rmask[3] && s1.cmask[1]) ? win_next[3][1] : '0;
    tap.v33   = (s1.rmask[3] && s1.cmask[3]) ? win_next[3][3] : '0;
  end

endmodule

`default_nettype wire

// File: src/bdm_kernel.sv
// Kernel pipeline: tap register, grouped tap sums, MHC kernels with
// divide-by-16 and saturation, and the output register. Depends on bdm_pkg.
`default_nettype none

module bdm_kernel (
  input  logic                clk,
  input  logic                rst,
  input  logic                tap_valid,
  output logic                tap_stall,
  input  bdm_pkg::tap_t       tap,
  output logic                rgb_valid,
  input  logic                rgb_stall,
  output bdm_pkg::pix_out_t   rgb
);
  import bdm_pkg::*;

  typedef struct packed {
    phase_t           phase;
    logic             last;
    logic [PIX_W-1:0] cen;
    logic [PIX_W:0]   ver;
    logic [PIX_W:0]   hor;
    logic [PIX_W:0]   far_v;
    logic [PIX_W:0]   far_h;
    logic [PIX_W+1:0] dia;
  } sum_t;

  // Green at a red or blue site
  function automatic logic signed [KS_W-1:0] k_cross(sum_t s);
    logic signed [KS_W-1:0] c, v, h, fv, fh;
    c  = KS_W'(s.cen);
    v  = KS_W'(s.ver);
    h  = KS_W'(s.hor);
    fv = KS_W'(s.far_v);
    fh = KS_W'(s.far_h);
    return (c <<< 3) + ((v + h) <<< 2) - ((fv + fh) <<< 1);
  endfunction

  // Color whose samples sit left and right of a green site
  function automatic logic signed [KS_W-1:0] k_row(sum_t s);
    logic signed [KS_W-1:0] c, h, fv, fh, d;
    c  = KS_W'(s.cen);
    h  = KS_W'(s.hor);
    fv = KS_W'(s.far_v);
    fh = KS_W'(s.far_h);
    d  = KS_W'(s.dia);
    return (c <<< 3) + (c <<< 1) + (h <<< 3) - (fh <<< 1) - (d <<< 1) + fv;
  endfunction

  // Color whose samples sit above and below a green site
  function automatic logic signed [KS_W-1:0] k_col(sum_t s);
    logic signed [KS_W-1:0] c, v, fv, fh, d;
    c  = KS_W'(s.cen);
    v  = KS_W'(s.ver);
    fv = KS_W'(s.far_v);
    fh = KS_W'(s.far_h);
    d  = KS_W'(s.dia);
    return (c <<< 3) + (c <<< 1) + (v <<< 3) - (fv <<< 1) - (d <<< 1) + fh;
  endfunction

  // Red at a blue site, blue at a red site
  function automatic logic signed [KS_W-1:0] k_diag(sum_t s);
    logic signed [KS_W-1:0] c, f, d;
    c = KS_W'(s.cen);
    f = KS_W'(s.far_v) + KS_W'(s.far_h);
    d = KS_W'(s.dia);
    return (c <<< 3) + (c <<< 2) + (d <<< 2) - f - (f <<< 1);
  endfunction

  // Clamp negatives to zero, floor-divide by 16, saturate to 255
  function automatic logic [PIX_W-1:0] finish(logic signed [KS_W-1:0] s);
    logic [KS_W-6:0] q;
    q = s[KS_W-2:4];
    if (s[KS_W-1]) begin
      return '0;
    end else if (q[KS_W-6:PIX_W] != '0) begin
      return '1;
    end else begin
      return q[PIX_W-1:0];
    end
  endfunction

  logic                   s2_valid, s3_valid;
  tap_t                   s2;
  sum_t                   s3, s3_next;
  pix_out_t               rgb_next;
  logic                   go_out, free3, free2;
  logic signed [KS_W-1:0] kc, kr, kl, kd;

  // Stage enables: a stage loads when it is empty or its item moves on
  assign go_out    = !rgb_valid || !rgb_stall;
  assign free3     = !s3_valid || go_out;
  assign free2     = !s2_valid || free3;
  assign tap_stall = !free2;

  // Group the taps that share a coefficient
  always_comb begin
    s3_next.phase = s2.phase;
    s3_next.last  = s2.last;
    s3_next.cen   = s2.v22;
    s3_next.ver   = (PIX_W+1)'(s2.v12) + (PIX_W+1)'(s2.v32);
    s3_next.hor   = (PIX_W+1)'(s2.v21) + (PIX_W+1)'(s2.v23);
    s3_next.far_v = (PIX_W+1)'(s2.v02) + (PIX_W+1)'(s2.v42);
    s3_next.far_h = (PIX_W+1)'(s2.v20) + (PIX_W+1)'(s2.v24);
    s3_next.dia   = (PIX_W+2)'(s2.v11) + (PIX_W+2)'(s2.v13) +
                    (PIX_W+2)'(s2.v31) + (PIX_W+2)'(s2.v33);
  end

  // Kernels and color selection by phase
  always_comb begin
    kc = k_cross(s3);
    kr = k_row(s3);
    kl = k_col(s3);
    kd = k_diag(s3);
    rgb_next.frame_last = s3.last;
    unique case (s3.phase)
      PH_RED: begin
        rgb_next.red_out   = s3.cen;
        rgb_next.green_out = finish(kc);
        rgb_next.blue_out  = finish(kd);
      end
      PH_GREEN_R: begin
        rgb_next.red_out   = finish(kr);
        rgb_next.green_out = s3.cen;
        rgb_next.blue_out  = finish(kl);
      end
      PH_GREEN_B: begin
        rgb_next.red_out   = finish(kl);
        rgb_next.green_out = s3.cen;
        rgb_next.blue_out  = finish(kr);
      end
      PH_BLUE: begin
        rgb_next.red_out   = finish(kd);
        rgb_next.green_out = finish(kc);
        rgb_next.blue_out  = s3.cen;
      end
      default: begin
        rgb_next.red_out   = '0;
        rgb_next.green_out = '0;
        rgb_next.blue_out  = '0;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (free2) begin
        s2_valid <= tap_valid;
      end
      if (free3) begin
        s3_valid <= s2_valid;
      end
      if (go_out) begin
        rgb_valid <= s3_valid;
      end
    end
  end

  // Payload: advance each stage with its item
  always_ff @(posedge clk) begin
    if (free2 && tap_valid) begin
      s2 <= tap;
    end
    if (free3 && s2_valid) begin
      s3 <= s3_next;
    end
    if (go_out && s3_valid) begin
      rgb <= rgb_next;
    end
  end

endmodule

`default_nettype wire

// File: src/bayer_demosaic_mhc_5x5_top.sv
// Top level of the Bayer MHC 5x5 demosaic block: configuration registers,
// front end and kernel pipeline. Depends on bdm_pkg, bdm_front, bdm_kernel.
//
// Takes one raw RGGB sample per item in raster order and returns one RGB
// item for each frame pixel, red at even row and even column. The block
// sustains one item per clock unless stalled: the line-store RAM (one word
// of four row bytes per column) takes the read for the new item and the
// write-back of the previous one in the same cycle. The result for pixel k
// follows the item that completes its window, which is input number
// k + 2*W + 2 of the frame; feed 2*W + 2 flush items after the last sample
// to drain the frame. frame_last marks the last pixel, after which a new
// frame starts. Pixels outside the frame count as zero; the line RAM needs
// no clearing pass after reset. Width and height are clamped to 5..MAX_WIDTH
// and 5..1024 when written, and may only be changed while the block is idle.
`default_nettype none

module bayer_demosaic_mhc_5x5_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  bdm_pkg::pix_in_t              pix,
  output logic                          rgb_valid,
  input  logic                          rgb_stall,
  output bdm_pkg::pix_out_t             rgb,
  input  logic                          cfg_wr_en,
  input  logic [bdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdm_pkg::CFG_W-1:0]     cfg_data
);
  import bdm_pkg::*;

  function automatic logic [WCNT_W-1:0] clamp_width(logic [CFG_W-1:0] d);
    if (d < CFG_W'(5)) begin
      return WCNT_W'(5);
    end else if (32'(d) > 32'(MAX_WIDTH)) begin
      return WCNT_W'(MAX_WIDTH);
    end else begin
      return WCNT_W'(d);
    end
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(logic [CFG_W-1:0] d);
    if (d < CFG_W'(5)) begin
      return ROW_W'(5);
    end else if (32'(d) > 32'(MAX_HEIGHT)) begin
      return ROW_W'(MAX_HEIGHT);
    end else begin
      return ROW_W'(d);
    end
  endfunction

  logic [WCNT_W-1:0] img_w;
  logic [ROW_W-1:0]  img_h;
  logic              tap_valid, tap_stall;
  tap_t              tap;

  // Configuration registers, stored already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= clamp_width(CFG_W'(256));
      img_h <= clamp_height(CFG_W'(256));
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w <= clamp_width(cfg_data);
        CFG_IMAGE_HEIGHT: img_h <= clamp_height(cfg_data);
        default: ;
      endcase
    end
  end

  bdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .img_w     (img_w),
    .img_h     (img_h),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .tap_valid (tap_valid),
    .tap_stall (tap_stall),
    .tap       (tap)
  );

  bdm_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (tap_valid),
    .tap_stall (tap_stall),
    .tap       (tap),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  // Input backs up only when the kernel pipeline is full
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> tap_stall)
    else $error("pixel input stalled while kernel pipeline had room");

  // A free output drains the whole kernel pipeline
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    !rgb_stall |-> !tap_stall && !pix_stall)
    else $error("stall raised while output was taking items");

  // Window taps hold while the kernel stage is stalled
  a_tap_hold: assert property (@(posedge clk) disable iff (rst)
    tap_valid && tap_stall |=> tap_valid && $stable(tap))
    else $error("window taps changed under stall");

endmodule

`default_nettype wire

// File: tb/tb_bayer_demosaic_mhc_5x5_top.sv
// Self-checking testbench for bayer_demosaic_mhc_5x5_top: streams RGGB frames through the
// block and compares every RGB item with a local predictor of the 5x5 demosaic.
// Depends on bdm_pkg and the block's RTL only.
module tb_bayer_demosaic_mhc_5x5_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdm_pkg::*;

  localparam int MIN_DIM     = 5;
  localparam int ROW_SPAN    = 2048;
  localparam int SETTLE_CYC  = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int PRINT_LIMIT = 40;

  typedef enum int {GAPS_RX_HEAVY, GAPS_TX_HEAVY, GAPS_NONE} gap_mode_t;
  typedef enum int {TEX_UNIFORM, TEX_BINARY, TEX_SMOOTH} texture_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  pix_in_t              pix = '0;
  logic                 rgb_valid;
  logic                 rgb_stall = 1'b0;
  pix_out_t             rgb;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predictor state: register shadows, line rows, window, raster position
  logic [CFG_W-1:0] geom_width = 11'd256;
  logic [CFG_W-1:0] geom_height = 11'd256;
  bit [PIX_W-1:0]   line_mem [LINES][MAX_WIDTH];
  bit [PIX_W-1:0]   win [5][5];
  int               col_pos = 0;
  int               row_pos = 0;
  int               taps [5][5];

  pix_in_t  pending [$];
  pix_out_t rgb_expected [$];

  gap_mode_t idle_mode = GAPS_RX_HEAVY;
  int items_taken = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int errors = 0;
  int pushed_items = 0;
  int quiet_cycles = 0;

  bayer_demosaic_mhc_5x5_top dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_dim(input int v, input int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] to_byte(input int s);
    if (s < 0) return 8'd0;
    if (s / 16 > 255) return 8'hFF;
    return 8'(s / 16);
  endfunction

  function automatic int diag_sum();
    return taps[1][1] + taps[1][3] + taps[3][1] + taps[3][3];
  endfunction

  // green at a red or blue site
  function automatic int green_at_rb();
    return 8 * taps[2][2] + 4 * (taps[1][2] + taps[3][2] + taps[2][1] + taps[2][3])
           - 2 * (taps[0][2] + taps[4][2] + taps[2][0] + taps[2][4]);
  endfunction

  // color whose samples sit left and right of a green site
  function automatic int horiz_interp();
    return 10 * taps[2][2] + 8 * (taps[2][1] + taps[2][3]) - 2 * (taps[2][0] + taps[2][4])
           - 2 * diag_sum() + (taps[0][2] + taps[4][2]);
  endfunction

  // color whose samples sit above and below a green site
  function automatic int vert_interp();
    return 10 * taps[2][2] + 8 * (taps[1][2] + taps[3][2]) - 2 * (taps[0][2] + taps[4][2])
           - 2 * diag_sum() + (taps[2][0] + taps[2][4]);
  endfunction

  // red at a blue site, blue at a red site
  function automatic int diag_interp();
    return 12 * taps[2][2] + 4 * diag_sum()
           - 3 * (taps[0][2] + taps[4][2] + taps[2][0] + taps[2][4]);
  endfunction

  task automatic predict_rgb(input pix_in_t item);
    int w, h, ic, ir, ctr_r, ctr_c, pr, pc, r, c, k;
    int red_s, grn_s, blu_s;
    bit [PIX_W-1:0] new_px;
    bit [PIX_W-1:0] fresh [5];
    phase_t ph;
    pix_out_t res;
    w = clamp_dim(int'(geom_width), MAX_WIDTH);
    h = clamp_dim(int'(geom_height), MAX_HEIGHT);
    // a narrowed row sends the position to the start of the next row
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % ROW_SPAN;
    end
    ic = col_pos;
    ir = row_pos;
    new_px = item.flush_tick ? 8'd0 : item.pixel_in;
    for (k = 0; k < LINES; k++) fresh[k] = line_mem[(ir + k) % LINES][ic];
    fresh[4] = new_px;
    line_mem[ir % LINES][ic] = new_px;
    // shift the window left, newest column enters on the right
    for (r = 0; r < 5; r++) begin
      for (c = 0; c < 4; c++) win[r][c] = win[r][c + 1];
      win[r][4] = fresh[r];
    end
    if (ic >= 2) begin
      ctr_r = ir - 2;
      ctr_c = ic - 2;
    end else begin
      ctr_r = ir - 3;
      ctr_c = ic + w - 2;
    end
    if (ic + 1 >= w) begin
      col_pos = 0;
      row_pos = (ir + 1) % ROW_SPAN;
    end else begin
      col_pos = ic + 1;
    end
    if (ctr_r >= 0 && ctr_r < h) begin
      // zero every tap that falls outside the frame
      for (r = 0; r < 5; r++) begin
        for (c = 0; c < 5; c++) begin
          pr = ctr_r - 2 + r;
          pc = ctr_c - 2 + c;
          taps[r][c] = (pr >= 0 && pr < h && pc >= 0 && pc < w) ? int'(win[r][c]) : 0;
        end
      end
      ph = phase_t'({ctr_r[0], ctr_c[0]});
      case (ph)
        PH_RED: begin
          red_s = 16 * taps[2][2];
          grn_s = green_at_rb();
          blu_s = diag_interp();
        end
        PH_GREEN_R: begin
          red_s = horiz_interp();
          grn_s = 16 * taps[2][2];
          blu_s = vert_interp();
        end
        PH_GREEN_B: begin
          red_s = vert_interp();
          grn_s = 16 * taps[2][2];
          blu_s = horiz_interp();
        end
        default: begin
          red_s = diag_interp();
          grn_s = green_at_rb();
          blu_s = 16 * taps[2][2];
        end
      endcase
      res.red_out    = to_byte(red_s);
      res.green_out  = to_byte(grn_s);
      res.blue_out   = to_byte(blu_s);
      res.frame_last = (ctr_r == h - 1) && (ctr_c == w - 1);
      if (res.frame_last) begin
        col_pos = 0;
        row_pos = 0;
      end
      rgb_expected.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("%0t ns: result %0d %s: got %0d, expected %0d",
               $time, results_seen, what, got_v, want_v);
  endtask

  task automatic check_rgb(input pix_out_t got);
    pix_out_t want;
    results_seen++;
    if (got.frame_last === 1'b1) frames_seen++;
    if (rgb_expected.size() == 0) begin
      report_mismatch("with nothing expected, red", int'(got.red_out), -1);
    end else begin
      want = rgb_expected.pop_front();
      if (got.red_out !== want.red_out)
        report_mismatch("red_out", int'(got.red_out), int'(want.red_out));
      if (got.green_out !== want.green_out)
        report_mismatch("green_out", int'(got.green_out), int'(want.green_out));
      if (got.blue_out !== want.blue_out)
        report_mismatch("blue_out", int'(got.blue_out), int'(want.blue_out));
      if (got.frame_last !== want.frame_last)
        report_mismatch("frame_last", int'(got.frame_last), int'(want.frame_last));
    end
  endtask

  // ---------------------------------------------------------------- idling

  function automatic bit tx_gap();
    case (idle_mode)
      GAPS_RX_HEAVY: return $urandom_range(99) < 32;
      GAPS_TX_HEAVY: return $urandom_range(99) < 88;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit rx_gap();
    case (idle_mode)
      GAPS_RX_HEAVY: return $urandom_range(99) < 88;
      GAPS_TX_HEAVY: return $urandom_range(99) < 32;
      default:       return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  // Predict on acceptance, hold a stalled item, load the next one when free
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && !pix_stall) begin
        predict_rgb(pix);
        items_taken++;
      end
      if (!pix_valid || !pix_stall) begin
        if (pending.size() != 0 && !tx_gap()) begin
          pix       <= pending.pop_front();
          pix_valid <= 1'b1;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted RGB item, then pick the next stall value
  always @(posedge clk) begin
    if (rst) begin
      rgb_stall <= 1'b0;
    end else begin
      if (rgb_valid && !rgb_stall) check_rgb(rgb);
      rgb_stall <= rx_gap();
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (rgb_valid && !rgb_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [PIX_W-1:0] random_pixel(input texture_t tex);
    case (tex)
      TEX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
      TEX_SMOOTH: return 8'($urandom_range(96, 160));
      default:    return 8'($urandom);
    endcase
  endfunction

  task automatic push_item(input logic [PIX_W-1:0] value, input logic flush);
    pix_in_t item;
    item.pixel_in   = value;
    item.flush_tick = flush;
    pending.push_back(item);
    pushed_items++;
  endtask

  // Frame pixels, with an occasional flush item in the middle of the frame
  task automatic push_body(input int count, input texture_t tex);
    int k;
    for (k = 0; k < count; k++) push_item(random_pixel(tex), $urandom_range(31) == 0);
  endtask

  // Drain items after the frame: mostly flush, some stray pixels
  task automatic push_drain(input int count);
    int k;
    for (k = 0; k < count; k++) push_item(8'($urandom), $urandom_range(3) != 0);
  endtask

  // Wait until the block has nothing in flight
  task automatic settle();
    while (pending.size() != 0 || pix_valid || rgb_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) geom_width = value[CFG_W-1:0];
    else geom_height = value[CFG_W-1:0];
  endtask

  task automatic run_frame(input int w_reg, input int h_reg, input texture_t tex,
                           input bit rewrite);
    int w, h;
    if (rewrite) begin
      settle();
      write_reg(CFG_IMAGE_WIDTH, w_reg);
      write_reg(CFG_IMAGE_HEIGHT, h_reg);
    end
    w = clamp_dim(int'(geom_width), MAX_WIDTH);
    h = clamp_dim(int'(geom_height), MAX_HEIGHT);
    push_body(w * h, tex);
    push_drain(2 * w + 2);
  endtask

  // Small frames, mostly new geometry, sometimes back to back with the old one
  task automatic random_frames(input int count);
    int start, w_reg, h_reg;
    bit rewrite;
    start = pushed_items;
    rewrite = 1'b1;
    while (pushed_items - start < count) begin
      w_reg = ($urandom_range(9) == 0) ? $urandom_range(0, MIN_DIM - 1)
                                       : $urandom_range(MIN_DIM, 24);
      h_reg = ($urandom_range(9) == 0) ? $urandom_range(0, MIN_DIM - 1)
                                       : $urandom_range(MIN_DIM, 12);
      run_frame(w_reg, h_reg, texture_t'($urandom_range(2)), rewrite);
      rewrite = $urandom_range(2) != 0;
    end
  endtask

  // Minimum frame: checkerboard over solid rows, a flush at the center,
  // stray full-scale pixels among the drain items
  task automatic directed_frame();
    int r, c, k;
    settle();
    write_reg(CFG_IMAGE_WIDTH, MIN_DIM);
    write_reg(CFG_IMAGE_HEIGHT, MIN_DIM);
    for (r = 0; r < MIN_DIM; r++) begin
      for (c = 0; c < MIN_DIM; c++) begin
        if (r == 2 && c == 2) push_item(8'hA5, 1'b1);
        else push_item((r < 3 && ((r + c) % 2) == 1) ? 8'h00 : 8'hFF, 1'b0);
      end
    end
    for (k = 0; k < 2 * MIN_DIM + 2; k++) push_item(k[0] ? 8'h5A : 8'hFF, k[0]);
  endtask

  // Narrow a 20-wide frame at row 3 column 13: the position jumps to row 4,
  // which leaves four rows of 10 plus the drain
  task automatic width_cut_case();
    settle();
    write_reg(CFG_IMAGE_WIDTH, 20);
    write_reg(CFG_IMAGE_HEIGHT, 8);
    push_body(3 * 20 + 13, TEX_UNIFORM);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 10);
    push_body(4 * 10, TEX_UNIFORM);
    push_drain(2 * 10 + 2);
  endtask

  // Cut a 5x10 frame to 5 rows after seven rows: two more items reach
  // the last center of row 4
  task automatic height_cut_case();
    settle();
    write_reg(CFG_IMAGE_WIDTH, MIN_DIM);
    write_reg(CFG_IMAGE_HEIGHT, 10);
    push_body(7 * MIN_DIM, TEX_UNIFORM);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, MIN_DIM);
    push_body(2, TEX_SMOOTH);
  endtask

  // Width below range clamps up, height above range clamps to the maximum:
  // twelve rows go by with no frame end, then a cut to 10 rows ends it
  task automatic tall_clamp_case();
    settle();
    write_reg(CFG_IMAGE_WIDTH, 3);
    write_reg(CFG_IMAGE_HEIGHT, 2047);
    push_body(12 * MIN_DIM, TEX_UNIFORM);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 10);
    push_body(2, TEX_UNIFORM);
  endtask

  // Width above range clamps to the maximum: thirty pixels stay in row 0,
  // then a cut to 10 wide moves on to row 1; full-scale texture saturates
  task automatic wide_clamp_case();
    settle();
    write_reg(CFG_IMAGE_WIDTH, 2047);
    write_reg(CFG_IMAGE_HEIGHT, 8);
    push_body(30, TEX_BINARY);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 10);
    push_body(7 * 10, TEX_BINARY);
    push_drain(2 * 10 + 2);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    idle_mode = GAPS_RX_HEAVY;
    directed_frame();
    tall_clamp_case();
    random_frames(400);

    idle_mode = GAPS_TX_HEAVY;
    width_cut_case();
    height_cut_case();
    random_frames(400);

    idle_mode = GAPS_NONE;
    wide_clamp_case();
    random_frames(400);

    settle();
    $display("Covered %0d pixel items, %0d RGB items, %0d frames, %0d mismatches",
             items_taken, results_seen, frames_seen, errors);
    $display("Geometry clamped at both ends, mid-frame width and height cuts, flush items");
    if (errors == 0 && rgb_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
